### rtl/unsorted_min_priority_queue_top_macros.svh
// assertion macros shared by the queue modules
`ifndef UNSORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH
`define UNSORTED_MIN_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define UMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define UMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/umpq_pkg.sv
// shared constants, types and command/status structs of the min-priority queue
package umpq_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 2;
  localparam int STAT_W      = 2;
  localparam int COUNT_OUT_W = 5;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [MODE_W-1:0]       mode_t;
  typedef logic [STAT_W-1:0]       stat_code_t;

  localparam mode_t MODE_QUERY  = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam stat_code_t ST_OK    = 2'd0;
  localparam stat_code_t ST_FULL  = 2'd1;
  localparam stat_code_t ST_EMPTY = 2'd2;

  typedef struct packed {
    logic start;   // item accepted, latch it and begin the scan
    logic finish;  // commit the operation and load the result register
  } umpq_cmd_t;

  typedef struct packed {
    logic scan_done;  // last entry is being compared this cycle
    logic out_free;   // result register can take a new item
  } umpq_stat_t;

endpackage

### rtl/umpq_ifs.sv
// valid/ready channel interfaces for queue operations and results
interface umpq_in_if import umpq_pkg::*;;
  logic  valid;
  logic  ready;
  mode_t mode;
  val_t  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface umpq_out_if import umpq_pkg::*;;
  logic                   valid;
  logic                   ready;
  val_t                   taken_value;
  val_t                   min_value;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;
  stat_code_t             status;

  modport source (output valid, output taken_value, output min_value, output entry_count,
                  output is_empty, output status, input ready);
  modport sink (input valid, input taken_value, input min_value, input entry_count,
                input is_empty, input status, output ready);
endinterface

### rtl/unsorted_min_priority_queue_top.sv
// top level of the unsorted-store min-priority queue
// the min scan compares one entry per cycle over the single read port of the entry store; a new item
// is accepted once the previous one has committed, and an unread result stalls only the commit
// reset: synchronous active-low rst_n clears valid marks, count and control; entry data
// is not cleared and is only read through its valid mark
module unsorted_min_priority_queue_top import umpq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  umpq_in_if.sink  in_ch,
  umpq_out_if.source out_ch
);

  umpq_cmd_t  cmd;
  umpq_stat_t stat;

  umpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  umpq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_ch.mode),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_taken_value (out_ch.taken_value),
    .out_min_value   (out_ch.min_value),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_status      (out_ch.status)
  );

endmodule

### rtl/umpq_ctrl.sv
// controller: sequences accept, scan and commit of one queue operation
module umpq_ctrl import umpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  umpq_stat_t stat,
  output umpq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready   = in_ready_r;
  assign cmd.start  = in_valid && in_ready_r;
  assign cmd.finish = (state_r == S_COMMIT) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            state_r    <= S_SCAN;
            in_ready_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          // hold until the previous result has been taken
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

`include "unsorted_min_priority_queue_top_macros.svh"

  `UMPQ_ASSERT_NOW(a_ready_only_idle, in_ready_r, state_r == S_IDLE, "ready outside idle")
  `UMPQ_ASSERT_NOW(a_done_in_scan, stat.scan_done, state_r == S_SCAN, "scan done outside scan")
  `UMPQ_ASSERT_NEXT(a_finish_reopens, cmd.finish, in_ready_r, "not ready after commit")

endmodule

### rtl/umpq_dp.sv
// datapath: entry store, valid marks, count, min scan and result register
module umpq_dp import umpq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  umpq_cmd_t              cmd,
  output umpq_stat_t             stat,
  input  mode_t                  in_mode,
  input  val_t                   in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output val_t                   out_taken_value,
  output val_t                   out_min_value,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  output logic                   out_is_empty,
  output stat_code_t             out_status
);

  val_t             mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  cnt_t             count_r;

  mode_t op_mode_r;
  val_t  op_value_r;

  // scan pipeline: address issue, then registered read and compare
  logic issuing_r;
  idx_t rd_idx_r;
  logic stg_vld_r;
  idx_t stg_idx_r;
  logic stg_ent_r;
  val_t rd_data_r;

  // running smallest and second smallest, first free slot
  logic best_has_r;
  val_t best_r;
  idx_t best_idx_r;
  logic sec_has_r;
  val_t sec_r;
  logic free_found_r;
  idx_t free_idx_r;

  logic                   out_valid_r;
  val_t                   out_taken_r;
  val_t                   out_min_r;
  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic                   out_empty_r;
  stat_code_t             out_status_r;

  logic       last_issue;
  logic       take_best;
  logic       take_sec;
  logic       take_free;
  logic       wr_en;
  logic       clr_en;
  cnt_t       cnt_nxt;
  val_t       taken_nxt;
  val_t       min_nxt;
  stat_code_t status_nxt;

  assign last_issue = issuing_r && (rd_idx_r == IDX_W'(DEPTH - 1));

  assign stat.scan_done = stg_vld_r && (stg_idx_r == IDX_W'(DEPTH - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // strict less keeps the lowest index among equal values
  assign take_best = stg_vld_r && stg_ent_r && (!best_has_r || (rd_data_r < best_r));
  assign take_sec  = stg_vld_r && stg_ent_r && !take_best && (!sec_has_r || (rd_data_r < sec_r));
  assign take_free = stg_vld_r && !stg_ent_r && !free_found_r;

  always_comb begin
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    cnt_nxt    = count_r;
    taken_nxt  = '0;
    status_nxt = ST_OK;
    min_nxt    = best_has_r ? best_r : '0;
    case (op_mode_r)
      MODE_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_t'(count_r + 1'b1);
          if (!best_has_r || (op_value_r < best_r)) begin
            min_nxt = op_value_r;
          end
        end
      end
      MODE_REMOVE: begin
        if (!best_has_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          clr_en    = 1'b1;
          cnt_nxt   = cnt_t'(count_r - 1'b1);
          taken_nxt = best_r;
          min_nxt   = sec_has_r ? sec_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      issuing_r    <= 1'b0;
      rd_idx_r     <= '0;
      stg_vld_r    <= 1'b0;
      best_has_r   <= 1'b0;
      sec_has_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      stg_vld_r <= issuing_r;
      if (cmd.start) begin
        issuing_r    <= 1'b1;
        rd_idx_r     <= '0;
        best_has_r   <= 1'b0;
        sec_has_r    <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (issuing_r) begin
          rd_idx_r <= idx_t'(rd_idx_r + 1'b1);
        end
        if (last_issue) begin
          issuing_r <= 1'b0;
        end
        if (take_best) begin
          best_has_r <= 1'b1;
          sec_has_r  <= best_has_r;
        end else if (take_sec) begin
          sec_has_r <= 1'b1;
        end
        if (take_free) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_r     <= cnt_nxt;
        out_valid_r <= 1'b1;
        if (wr_en) begin
          valid_r[free_idx_r] <= 1'b1;
        end
        if (clr_en) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stg_idx_r <= rd_idx_r;
    stg_ent_r <= valid_r[rd_idx_r];
    if (cmd.start) begin
      op_mode_r  <= in_mode;
      op_value_r <= in_value;
    end
    if (take_best) begin
      best_r     <= rd_data_r;
      best_idx_r <= stg_idx_r;
      sec_r      <= best_r;
    end else if (take_sec) begin
      sec_r <= rd_data_r;
    end
    if (take_free) begin
      free_idx_r <= stg_idx_r;
    end
    if (cmd.finish) begin
      out_taken_r  <= taken_nxt;
      out_min_r    <= min_nxt;
      out_cnt_r    <= COUNT_OUT_W'(cnt_nxt);
      out_empty_r  <= (cnt_nxt == '0);
      out_status_r <= status_nxt;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem_r[free_idx_r] <= op_value_r;
    end
    rd_data_r <= mem_r[rd_idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_taken_value = out_taken_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;
  assign out_status      = out_status_r;

`include "unsorted_min_priority_queue_top_macros.svh"

  `UMPQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `UMPQ_ASSERT_NOW(a_count_marks, 1'b1, $countones(valid_r) == count_r, "count off valid marks")
  `UMPQ_ASSERT_NOW(a_finish_idle, cmd.finish, !issuing_r && !stg_vld_r, "commit during scan")

endmodule
